// ===== sv/arss_pkg.sv =====
package arss_pkg;

	// Register indexes on the configuration channel
	localparam logic [1:0] REG_RANK_COUNT      = 2'd0;
	localparam logic [1:0] REG_MY_INDEX        = 2'd1;
	localparam logic [1:0] REG_STEPS_PER_PHASE = 2'd2;

	localparam int MAX_RANKS_DEF = 64;
	localparam int RESULT_LIMIT  = 32;

	// Remainder unit: dividend width and divisor (rank) width
	localparam int XW = 8;
	localparam int RW = 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ME,
		ST_D,
		ST_PEER,
		ST_EMIT,
		ST_ERR
	} state_t;

endpackage

// ===== sv/arss_rem.sv =====
// Restoring remainder, one conditional subtract per cycle.
module arss_rem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [arss_pkg::XW-1:0]   x,
	input  logic [arss_pkg::RW-1:0]   m,
	output logic                      done,
	output logic [arss_pkg::RW-1:0]   rem
);

	localparam int SW   = arss_pkg::XW + arss_pkg::RW - 1;
	// m >= 2, so m << (XW-1) already exceeds any x
	localparam int KTOP = arss_pkg::XW - 2;

	logic                    active_q;
	logic                    done_q;
	logic [2:0]              k_q;
	logic [arss_pkg::XW-1:0] x_q;
	logic [SW-1:0]           shifted;
	logic [SW-1:0]           x_ext;
	logic [SW-1:0]           diff;
	logic                    ge;

	assign shifted = SW'(m) << k_q;
	assign x_ext   = SW'(x_q);
	assign ge      = x_ext >= shifted;
	assign diff    = x_ext - shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			k_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				k_q      <= 3'(KTOP);
			end else if (active_q) begin
				k_q <= k_q - 3'd1;
				if (k_q == 3'd0) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
		end else if (active_q && ge) begin
			x_q <= diff[arss_pkg::XW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = x_q[arss_pkg::RW-1:0];

endmodule

// ===== sv/allreduce_step_schedule_top.sv =====
// Step schedule for a reduce-scatter / all-gather all-reduce. Pulse start with
// step_number while busy is low; the block then gives the phase, the peers and
// one result per exchanged slice pair on result_strobe, last marking the final
// one. The receiver cannot stall: each result is on the ports for exactly one
// cycle. From accept until busy falls, an item runs two passes of the shared
// 7-step remainder unit (my_index mod R, distance mod R), one setup state, then
// one result per cycle, 1 to 32 results in all. A step beyond both phases
// gives a single error result in the cycle after it is accepted.
// cfg_ready is always high; write configuration only while busy is low.
module allreduce_step_schedule_top #(
	parameter int MAX_RANKS = arss_pkg::MAX_RANKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [3:0] step_number,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	output logic       result_strobe,
	output logic       phase,
	output logic [5:0] to_rank,
	output logic [5:0] from_rank,
	output logic [5:0] slice_count,
	output logic [5:0] tx_slice,
	output logic [5:0] rx_slice,
	output logic       last,
	output logic       step_error
);

	localparam int RW = arss_pkg::RW;
	localparam int XW = arss_pkg::XW;
	localparam logic [RW-1:0] RMAX = (MAX_RANKS > 127) ? 7'd127 : RW'(MAX_RANKS);

	// (a - b) mod r and (a + b) mod r for a, b < r
	function automatic logic [RW-1:0] mod_sub(input logic [RW-1:0] a,
			input logic [RW-1:0] b, input logic [RW-1:0] r);
		logic [RW:0] t;
		t = {1'b0, a} + {1'b0, r} - {1'b0, b};
		if (t >= {1'b0, r})
			t = t - {1'b0, r};
		return t[RW-1:0];
	endfunction

	function automatic logic [RW-1:0] mod_add(input logic [RW-1:0] a,
			input logic [RW-1:0] b, input logic [RW-1:0] r);
		logic [RW:0] t;
		t = {1'b0, a} + {1'b0, b};
		if (t >= {1'b0, r})
			t = t - {1'b0, r};
		return t[RW-1:0];
	endfunction

	arss_pkg::state_t state_q, state_d;

	logic [RW-1:0] rank_count_q;
	logic [5:0]    my_index_q;
	logic [2:0]    steps_q;

	logic          ph_q;
	logic [XW-1:0] d_q;
	logic [RW-1:0] r_q;
	logic [5:0]    n_q;
	logic [5:0]    cnt_q;
	logic [RW-1:0] me_q;
	logic [RW-1:0] dm_q;
	logic [RW-1:0] gm_q;
	logic [RW-1:0] to_q;
	logic [RW-1:0] from_q;
	logic [RW-1:0] tx_q;
	logic [RW-1:0] rx_q;

	logic          accept;
	logic          err_c;
	logic          ph_c;
	logic [3:0]    e_wide;
	logic [2:0]    e_c;
	logic [RW-1:0] r_c;
	logic [XW-1:0] d_c;
	logic [XW-1:0] sum_c;
	logic [XW-1:0] n_raw_c;
	logic [5:0]    n_c;

	logic          rem_start;
	logic [XW-1:0] rem_x;
	logic          rem_done;
	logic [RW-1:0] rem_r;

	logic [RW-1:0] minus_c;
	logic [RW-1:0] plus_c;
	logic [XW-1:0] g2_c;
	logic          is_err;
	logic          is_last;

	assign accept    = start && (state_q == arss_pkg::ST_IDLE);
	assign busy      = state_q != arss_pkg::ST_IDLE;
	assign cfg_ready = 1'b1;

	// Step decode
	assign err_c  = step_number >= {steps_q, 1'b0};
	assign ph_c   = step_number >= {1'b0, steps_q};
	assign e_wide = {steps_q, 1'b0} - 4'd1 - step_number;
	assign e_c    = ph_c ? e_wide[2:0] : step_number[2:0];
	assign r_c    = (rank_count_q < 7'd2) ? 7'd2 :
			((rank_count_q > RMAX) ? RMAX : rank_count_q);
	assign d_c    = XW'(1) << e_c;
	assign sum_c  = XW'(r_c) - XW'(1) + d_c;
	assign n_raw_c = sum_c >> ({1'b0, e_c} + 4'd1);
	assign n_c    = (n_raw_c > XW'(arss_pkg::RESULT_LIMIT)) ?
			6'(arss_pkg::RESULT_LIMIT) : n_raw_c[5:0];

	arss_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.x      (rem_x),
		.m      (r_q),
		.done   (rem_done),
		.rem    (rem_r)
	);

	assign minus_c = mod_sub(me_q, dm_q, r_q);
	assign plus_c  = mod_add(me_q, dm_q, r_q);
	assign g2_c    = {dm_q, 1'b0};

	assign is_err  = state_q == arss_pkg::ST_ERR;
	assign is_last = is_err || (n_q == 6'd0) || ((cnt_q + 6'd1) == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= arss_pkg::ST_IDLE;
			rank_count_q <= 7'd2;
			my_index_q   <= 6'd0;
			steps_q      <= 3'd1;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					arss_pkg::REG_RANK_COUNT:      rank_count_q <= cfg_data;
					arss_pkg::REG_MY_INDEX:        my_index_q   <= cfg_data[5:0];
					arss_pkg::REG_STEPS_PER_PHASE: steps_q      <= cfg_data[2:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		rem_start = 1'b0;
		rem_x     = XW'(my_index_q);
		unique case (state_q)
			arss_pkg::ST_IDLE: begin
				if (start) begin
					if (err_c) begin
						state_d = arss_pkg::ST_ERR;
					end else begin
						state_d   = arss_pkg::ST_ME;
						rem_start = 1'b1;
					end
				end
			end
			arss_pkg::ST_ME: begin
				rem_x = d_q;
				if (rem_done) begin
					state_d   = arss_pkg::ST_D;
					rem_start = 1'b1;
				end
			end
			arss_pkg::ST_D: begin
				if (rem_done)
					state_d = arss_pkg::ST_PEER;
			end
			arss_pkg::ST_PEER: state_d = arss_pkg::ST_EMIT;
			arss_pkg::ST_EMIT: begin
				if (is_last)
					state_d = arss_pkg::ST_IDLE;
			end
			arss_pkg::ST_ERR: state_d = arss_pkg::ST_IDLE;
			default: state_d = arss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ph_q <= ph_c;
			d_q  <= d_c;
			r_q  <= r_c;
			n_q  <= n_c;
		end
		if (state_q == arss_pkg::ST_ME && rem_done)
			me_q <= rem_r;
		if (state_q == arss_pkg::ST_D && rem_done)
			dm_q <= rem_r;
		if (state_q == arss_pkg::ST_PEER) begin
			cnt_q <= 6'd0;
			gm_q  <= ({1'b0, g2_c} >= {2'b0, r_q}) ? RW'(g2_c - XW'(r_q)) : RW'(g2_c);
			if (!ph_q) begin
				to_q   <= minus_c;
				from_q <= plus_c;
				tx_q   <= (n_q == 6'd0) ? '0 : minus_c;
				rx_q   <= (n_q == 6'd0) ? '0 : me_q;
			end else begin
				to_q   <= plus_c;
				from_q <= minus_c;
				tx_q   <= (n_q == 6'd0) ? '0 : me_q;
				rx_q   <= (n_q == 6'd0) ? '0 : minus_c;
			end
		end
		if (state_q == arss_pkg::ST_EMIT) begin
			cnt_q <= cnt_q + 6'd1;
			tx_q  <= mod_sub(tx_q, gm_q, r_q);
			rx_q  <= mod_sub(rx_q, gm_q, r_q);
		end
	end

	assign result_strobe = (state_q == arss_pkg::ST_EMIT) || is_err;
	assign phase         = is_err ? 1'b0 : ph_q;
	assign to_rank       = is_err ? 6'd0 : to_q[5:0];
	assign from_rank     = is_err ? 6'd0 : from_q[5:0];
	assign slice_count   = is_err ? 6'd0 : n_q;
	assign tx_slice      = is_err ? 6'd0 : tx_q[5:0];
	assign rx_slice      = is_err ? 6'd0 : rx_q[5:0];
	assign last          = is_last;
	assign step_error    = is_err;

endmodule

// ===== sv/arss_chk.sv =====
module arss_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_strobe,
	input logic [5:0] to_rank,
	input logic [5:0] slice_count,
	input logic       last,
	input logic       step_error
);

	// Results only come out while an item is in flight
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result outside of an item");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// Nothing follows the final result of an item
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |=> !result_strobe && !busy)
		else $error("result after last");

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && step_error) |-> (last && to_rank == 6'd0 && slice_count == 6'd0))
		else $error("malformed error result");

endmodule

bind allreduce_step_schedule_top arss_chk u_arss_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.to_rank       (to_rank),
	.slice_count   (slice_count),
	.last          (last),
	.step_error    (step_error)
);

// ===== bench/allreduce_step_schedule_top_tb.sv =====
`timescale 1ns / 100ps

module allreduce_step_schedule_top_tb;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int STEP_ITEMS = 450;

	typedef struct packed {
		logic       ph;
		logic [5:0] to_r;
		logic [5:0] from_r;
		logic [5:0] cnt;
		logic [5:0] tx;
		logic [5:0] rx;
		logic       lst;
		logic       err;
	} slot_t;

	typedef struct {
		bit         is_cfg;
		logic [1:0] idx;
		logic [6:0] data;
		logic [3:0] stp;
	} job_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [3:0] step_number = '0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;
	logic       result_strobe;
	logic       phase;
	logic [5:0] to_rank;
	logic [5:0] from_rank;
	logic [5:0] slice_count;
	logic [5:0] tx_slice;
	logic [5:0] rx_slice;
	logic       last;
	logic       step_error;

	job_t  job_q[$];
	slot_t sched_q[$];
	int    err_cnt = 0;
	int    steps_done = 0;
	int    steps_queued = 0;

	// shadow of the block's registers
	logic [6:0] reg_ranks;
	logic [5:0] reg_me;
	logic [2:0] reg_steps;

	allreduce_step_schedule_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.step_number  (step_number),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_strobe(result_strobe),
		.phase        (phase),
		.to_rank      (to_rank),
		.from_rank    (from_rank),
		.slice_count  (slice_count),
		.tx_slice     (tx_slice),
		.rx_slice     (rx_slice),
		.last         (last),
		.step_error   (step_error)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_bad(input string what, input logic [6:0] got, input logic [6:0] want);
		err_cnt++;
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic add_cfg(input logic [1:0] idx, input logic [6:0] data);
		job_t j;
		j = '{is_cfg: 1'b1, idx: idx, data: data, stp: '0};
		job_q = {job_q, j};
	endtask

	task automatic add_step(input logic [3:0] stp);
		job_t j;
		j = '{is_cfg: 1'b0, idx: '0, data: '0, stp: stp};
		job_q = {job_q, j};
		steps_queued++;
	endtask

	function automatic void store_reg(input logic [1:0] idx, input logic [6:0] data);
		case (idx)
			arss_pkg::REG_RANK_COUNT:      reg_ranks = data;
			arss_pkg::REG_MY_INDEX:        reg_me = data[5:0];
			arss_pkg::REG_STEPS_PER_PHASE: reg_steps = data[2:0];
			default: ;
		endcase
	endfunction

	// Expected slice-pair schedule of one step, from the current register shadow
	function automatic void plan_step(input logic [3:0] stp);
		slot_t       x;
		int unsigned s, r, me, e, d, grp, dm, gm, n, tx, rx, i;
		s = reg_steps;
		r = reg_ranks;
		x = '0;
		x.lst = 1'b1;
		if (stp >= 2 * s) begin
			x.err = 1'b1;
			sched_q = {sched_q, x};
			return;
		end
		if (r < 2) r = 2;
		if (r > arss_pkg::MAX_RANKS_DEF) r = arss_pkg::MAX_RANKS_DEF;
		me = reg_me % r;
		x.ph = (stp >= s);
		e = x.ph ? 2 * s - 1 - stp : stp;
		d = 1 << e;
		grp = d << 1;
		dm = d % r;
		gm = grp % r;
		n = (r - 1 + d) / grp;
		if (!x.ph) begin
			x.to_r = 6'((me + r - dm) % r);
			x.from_r = 6'((me + dm) % r);
			rx = me;
			tx = x.to_r;
		end else begin
			x.from_r = 6'((me + r - dm) % r);
			x.to_r = 6'((me + dm) % r);
			tx = me;
			rx = x.from_r;
		end
		if (n == 0) begin
			sched_q = {sched_q, x};
			return;
		end
		if (n > arss_pkg::RESULT_LIMIT) n = arss_pkg::RESULT_LIMIT;
		x.cnt = 6'(n);
		for (i = 0; i < n; i++) begin
			x.tx = 6'(tx);
			x.rx = 6'(rx);
			x.lst = (i + 1 == n);
			sched_q = {sched_q, x};
			tx = (tx + r - gm) % r;
			rx = (rx + r - gm) % r;
		end
	endfunction

	// Driver: one item in flight on each channel, held until its handshake
	always @(posedge clk) begin
		job_t j;
		bit   took_step, took_cfg, nxt_start, nxt_cfg, calm;
		if (!arst_n) begin
			reg_ranks = 7'd2;
			reg_me = 6'd0;
			reg_steps = 3'd1;
		end else begin
			took_step = start && !busy;
			took_cfg = cfg_valid && cfg_ready;
			if (took_step) begin
				plan_step(step_number);
				steps_done++;
			end
			if (took_cfg)
				store_reg(cfg_index, cfg_data);
			nxt_start = start && !took_step;
			nxt_cfg = cfg_valid && !took_cfg;
			calm = steps_done >= 150 && steps_done < 260;
			if (!nxt_start && !nxt_cfg && job_q.size() > 0
					&& (calm || $urandom_range(99) >= 34)) begin
				if (job_q[0].is_cfg) begin
					// registers change only with the block idle and drained
					if (sched_q.size() == 0 && !busy && !result_strobe && !took_step) begin
						j = job_q.pop_front();
						cfg_index <= j.idx;
						cfg_data <= j.data;
						nxt_cfg = 1'b1;
					end
				end else begin
					j = job_q.pop_front();
					step_number <= j.stp;
					nxt_start = 1'b1;
				end
			end
			start <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	// Monitor: results cannot be held off, so every strobe is checked
	always @(posedge clk) begin
		slot_t x;
		if (arst_n && result_strobe) begin
			if (sched_q.size() == 0) begin
				report_bad("result with nothing pending", 7'd1, 7'd0);
			end else begin
				x = sched_q.pop_front();
				if (phase !== x.ph) report_bad("phase", 7'(phase), 7'(x.ph));
				if (to_rank !== x.to_r) report_bad("to_rank", 7'(to_rank), 7'(x.to_r));
				if (from_rank !== x.from_r)
					report_bad("from_rank", 7'(from_rank), 7'(x.from_r));
				if (slice_count !== x.cnt)
					report_bad("slice_count", 7'(slice_count), 7'(x.cnt));
				if (tx_slice !== x.tx) report_bad("tx_slice", 7'(tx_slice), 7'(x.tx));
				if (rx_slice !== x.rx) report_bad("rx_slice", 7'(rx_slice), 7'(x.rx));
				if (last !== x.lst) report_bad("last", 7'(last), 7'(x.lst));
				if (step_error !== x.err)
					report_bad("step_error", 7'(step_error), 7'(x.err));
			end
		end
	end

	initial begin
		int rk, rc, s, me, cnt, k;
		// reset configuration: both halves, first error step, top step
		add_step(4'd0);
		add_step(4'd1);
		add_step(4'd2);
		add_step(4'd15);
		// largest ring, top index
		add_cfg(arss_pkg::REG_RANK_COUNT, 7'd64);
		add_cfg(arss_pkg::REG_MY_INDEX, 7'd63);
		add_cfg(arss_pkg::REG_STEPS_PER_PHASE, 7'd6);
		add_cfg(REG_UNUSED, 7'h7f);
		add_step(4'd0);
		add_step(4'd5);
		add_step(4'd6);
		add_step(4'd11);
		add_step(4'd12);
		add_step(4'd15);
		// rank count below range, index beyond ring, too many steps (empty steps)
		add_cfg(arss_pkg::REG_RANK_COUNT, 7'd0);
		add_cfg(arss_pkg::REG_MY_INDEX, 7'd5);
		add_cfg(arss_pkg::REG_STEPS_PER_PHASE, 7'd7);
		add_step(4'd1);
		add_step(4'd6);
		add_step(4'd7);
		add_step(4'd13);
		add_step(4'd14);
		// rank count above range, upper data bit on my_index, no steps at all
		add_cfg(arss_pkg::REG_RANK_COUNT, 7'd127);
		add_cfg(arss_pkg::REG_MY_INDEX, 7'h7f);
		add_cfg(arss_pkg::REG_STEPS_PER_PHASE, 7'd0);
		add_step(4'd0);
		add_cfg(arss_pkg::REG_RANK_COUNT, 7'd1);
		add_cfg(arss_pkg::REG_MY_INDEX, 7'd0);
		add_cfg(arss_pkg::REG_STEPS_PER_PHASE, 7'd3);
		add_step(4'd2);
		add_step(4'd3);

		k = steps_queued;
		while (steps_queued < k + STEP_ITEMS) begin
			if ($urandom_range(3) == 0) rk = $urandom_range(127);
			else rk = $urandom_range(64, 2);
			rc = rk < 2 ? 2 : (rk > 64 ? 64 : rk);
			if ($urandom_range(4) == 0) s = $urandom_range(7);
			else s = $clog2(rc);
			if ($urandom_range(4) == 0) me = $urandom_range(127);
			else me = $urandom_range(rc - 1);
			add_cfg(arss_pkg::REG_RANK_COUNT, 7'(rk));
			add_cfg(arss_pkg::REG_MY_INDEX, 7'(me));
			add_cfg(arss_pkg::REG_STEPS_PER_PHASE, 7'(s));
			cnt = $urandom_range(40, 15);
			repeat (cnt) begin
				if (s == 0 || $urandom_range(7) == 0) add_step(4'($urandom_range(15)));
				else add_step(4'($urandom_range(2 * s - 1)));
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (job_q.size() > 0 || start || cfg_valid) @(posedge clk);
		while (sched_q.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
